// ===== design/assert_macros.svh =====
// shared assertion macros, clk and rst taken from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define RMJD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmjd assertion failed");

// cons must hold in the cycle after ante
`define RMJD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmjd assertion failed");

// cond must never hold
`define RMJD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rmjd assertion failed");

`endif

// ===== design/rmjd_pkg.sv =====
package rmjd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int TEMP_W = 16;
  localparam int HUM_W = 14;
  localparam int LIMIT_W = 16;
  localparam int SHOWN_W = 16;
  localparam int MEAN_W = 16;
  localparam int PROD_W = MEAN_W + COUNT_WIDTH;

  localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RESET = LIMIT_W'(50);

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
  } rmjd_sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] mean_temperature;
    logic [HUM_W-1:0]         mean_humidity;
    logic [SHOWN_W-1:0]       sample_count;
    logic                     rapid_change;
    logic signed [TEMP_W-1:0] previous_temperature;
  } rmjd_result_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic signed [MEAN_W-1:0] sample;
    logic [COUNT_WIDTH-1:0]   n;
  } rmjd_op_t;

endpackage

// ===== design/running_mean_jump_detector.sv =====
// Running mean and temperature jump detector. Each sample word yields one result word with
// the truncated running means of temperature and humidity, the saturating sample count,
// the jump flag and the previous temperature (-1 after reset). Each mean unit holds a
// bit-serial multiplier (one count bit per cycle) and a restoring divider (one quotient
// bit per cycle) with setup and hand-off steps; a new sample is taken only once the
// previous one has left both units and its result has moved on. A finished result waits
// in the output register while the next sample is processed. jump_limit is written
// through cfg_we and cfg_wdata, by the user only while the block is idle (the block does
// not enforce this), and resets to 50.
`include "assert_macros.svh"

module running_mean_jump_detector
  import rmjd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  rmjd_sample_t       sample,
  output logic               result_valid,
  input  logic               result_ready,
  output rmjd_result_t       result,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  function automatic logic [SHOWN_W-1:0] shown_count(input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+SHOWN_W-1:0] wide;
    wide = {{SHOWN_W{1'b0}}, c};
    if (wide > (COUNT_WIDTH+SHOWN_W)'({SHOWN_W{1'b1}})) begin
      return '1;
    end
    return wide[SHOWN_W-1:0];
  endfunction

  logic [LIMIT_W-1:0]       jump_limit;
  logic signed [MEAN_W-1:0] temp_mean;
  logic [HUM_W-1:0]         humid_mean;
  logic [COUNT_WIDTH-1:0]   count;
  logic signed [TEMP_W-1:0] last_temp;
  logic                     busy;
  logic                     pend;
  logic [SHOWN_W-1:0]       st_count;
  logic                     st_jump;
  logic signed [TEMP_W-1:0] st_prev;

  logic                     acc;
  logic                     move;
  logic [COUNT_WIDTH-1:0]   count_next;
  logic [TEMP_W:0]          diff;
  logic [TEMP_W:0]          diff_abs;
  logic                     jump;
  rmjd_op_t                 t_op;
  rmjd_op_t                 h_op;
  logic                     t_done;
  logic                     h_done;
  logic signed [MEAN_W-1:0] t_mean;
  logic signed [MEAN_W-1:0] h_mean;

  assign sample_ready = !busy && !pend;
  assign acc = sample_valid && sample_ready;
  assign move = pend && (!result_valid || result_ready);

  always_comb begin
    count_next = (count == COUNT_MAX) ? count : count + 1'b1;
    diff = {sample.temperature[TEMP_W-1], sample.temperature} - {last_temp[TEMP_W-1], last_temp};
    diff_abs = diff[TEMP_W] ? (~diff + 1'b1) : diff;
    jump = !last_temp[TEMP_W-1] && (diff_abs > {1'b0, jump_limit});
    t_op.mean = temp_mean;
    t_op.sample = sample.temperature;
    t_op.n = count;
    h_op.mean = {{(MEAN_W-HUM_W){1'b0}}, humid_mean};
    h_op.sample = {{(MEAN_W-HUM_W){1'b0}}, sample.humidity};
    h_op.n = count;
  end

  rmjd_mean_unit u_temp (
    .clk   (clk),
    .rst   (rst),
    .start (acc),
    .op    (t_op),
    .done  (t_done),
    .mean  (t_mean)
  );

  rmjd_mean_unit u_humid (
    .clk   (clk),
    .rst   (rst),
    .start (acc),
    .op    (h_op),
    .done  (h_done),
    .mean  (h_mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit <= JUMP_LIMIT_RESET;
      temp_mean <= '0;
      humid_mean <= '0;
      count <= '0;
      last_temp <= '1;
      busy <= 1'b0;
      pend <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        jump_limit <= cfg_wdata;
      end
      if (acc) begin
        busy <= 1'b1;
        count <= count_next;
        last_temp <= sample.temperature;
      end
      if (t_done) begin
        busy <= 1'b0;
        pend <= 1'b1;
        temp_mean <= t_mean;
        humid_mean <= h_mean[HUM_W-1:0];
      end
      if (move) begin
        pend <= 1'b0;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      st_count <= shown_count(count_next);
      st_jump <= jump;
      st_prev <= last_temp;
    end
    if (move) begin
      result.mean_temperature <= temp_mean;
      result.mean_humidity <= humid_mean;
      result.sample_count <= st_count;
      result.rapid_change <= st_jump;
      result.previous_temperature <= st_prev;
    end
  end

  `RMJD_ASSERT_NEVER(a_busy_pend, busy && pend)
  `RMJD_ASSERT_NEVER(a_units_lockstep, t_done != h_done)
  `RMJD_ASSERT_NXT(a_accept_busy, acc, busy && !sample_ready)

endmodule

// ===== design/rmjd_mean_unit.sv =====
`include "assert_macros.svh"

module rmjd_mean_unit
  import rmjd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  rmjd_op_t                 op,
  output logic                     done,
  output logic signed [MEAN_W-1:0] mean
);

  localparam int STEP_W = $clog2(COUNT_WIDTH > MEAN_W ? COUNT_WIDTH : MEAN_W);
  localparam int REM_W = COUNT_WIDTH + 1;
  localparam int TRIAL_W = REM_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]             state;
  logic [STEP_W-1:0]      step;
  logic [MEAN_W-1:0]      mcand;
  logic                   neg;
  logic [COUNT_WIDTH-1:0] mplier;
  logic [PROD_W-1:0]      prod;
  logic [MEAN_W-1:0]      addend;
  logic [REM_W-1:0]       dvsr;
  logic [PROD_W:0]        dvd;
  logic [REM_W-1:0]       rem;
  logic [MEAN_W-1:0]      quo;
  logic                   qneg;

  logic [MEAN_W-1:0]  mean_mag;
  logic [MEAN_W:0]    mul_sum;
  logic [PROD_W:0]    addend_ext;
  logic [PROD_W:0]    dvd_sum;
  logic [PROD_W:0]    dvd_mag;
  logic [TRIAL_W-1:0] trial;
  logic [TRIAL_W-1:0] trial_diff;
  logic               ge;

  always_comb begin
    mean_mag = op.mean[MEAN_W-1] ? (~op.mean + 1'b1) : op.mean;
    mul_sum = {1'b0, prod[PROD_W-1:COUNT_WIDTH]} + {1'b0, (mplier[0] ? mcand : '0)};
    addend_ext = {{(PROD_W+1-MEAN_W){addend[MEAN_W-1]}}, addend};
    dvd_sum = neg ? (addend_ext - {1'b0, prod}) : (addend_ext + {1'b0, prod});
    dvd_mag = dvd[PROD_W] ? (~dvd + 1'b1) : dvd;
    trial = {rem, quo[MEAN_W-1]};
    trial_diff = trial - {1'b0, dvsr};
    ge = trial >= {1'b0, dvsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (step == '0) begin
            state <= S_ADD;
          end
        end
        S_ADD: state <= S_ABS;
        S_ABS: state <= S_DIV;
        S_DIV: begin
          if (step == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          mcand <= mean_mag;
          neg <= op.mean[MEAN_W-1];
          mplier <= op.n;
          prod <= '0;
          addend <= op.sample;
          dvsr <= {1'b0, op.n} + 1'b1;
          step <= STEP_W'(COUNT_WIDTH - 1);
        end
      end
      S_MUL: begin
        prod <= {mul_sum, prod[COUNT_WIDTH-1:1]};
        mplier <= mplier >> 1;
        step <= step - 1'b1;
      end
      S_ADD: dvd <= dvd_sum;
      S_ABS: begin
        qneg <= dvd[PROD_W];
        rem <= {1'b0, dvd_mag[PROD_W-1:MEAN_W]};
        quo <= dvd_mag[MEAN_W-1:0];
        step <= STEP_W'(MEAN_W - 1);
      end
      S_DIV: begin
        rem <= ge ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
        quo <= {quo[MEAN_W-2:0], ge};
        step <= step - 1'b1;
      end
      S_FIN: mean <= qneg ? (~quo + 1'b1) : quo;
      default: ;
    endcase
  end

  `RMJD_ASSERT_IMP(a_start_idle, start, state == S_IDLE)
  `RMJD_ASSERT_IMP(a_rem_below_dvsr, state == S_DIV, rem < dvsr)
  `RMJD_ASSERT_IMP(a_quo_bound, state == S_FIN, !quo[MEAN_W-1] || quo[MEAN_W-2:0] == '0)

endmodule

// ===== dv/tb_running_mean_jump_detector.sv =====
module tb_running_mean_jump_detector;
  import rmjd_pkg::*;

  class mean_scoreboard;
    logic [LIMIT_W-1:0] jump_limit;
    longint temp_avg;
    longint hum_avg;
    longint count;
    longint last_temp;
    rmjd_result_t waiting[$];
    int errors;

    function new();
      jump_limit = JUMP_LIMIT_RESET;
      temp_avg = 0;
      hum_avg = 0;
      count = 0;
      last_temp = -1;
      errors = 0;
    endfunction

    // running means, saturating count and jump flag for one accepted word
    function void note_sample(rmjd_sample_t s);
      longint t;
      longint h;
      longint diff;
      longint cmax;
      rmjd_result_t e;
      t = longint'($signed(s.temperature));
      h = longint'(s.humidity);
      cmax = (longint'(1) << COUNT_WIDTH) - 1;
      temp_avg = (temp_avg * count + t) / (count + 1);
      hum_avg = (hum_avg * count + h) / (count + 1);
      diff = t - last_temp;
      if (diff < 0) diff = -diff;
      e.rapid_change = (last_temp >= 0) && (diff > longint'(jump_limit));
      e.previous_temperature = TEMP_W'(last_temp);
      if (count < cmax) count++;
      e.sample_count = (count > 65535) ? '1 : SHOWN_W'(count);
      e.mean_temperature = TEMP_W'(temp_avg);
      e.mean_humidity = HUM_W'(hum_avg);
      last_temp = t;
      waiting.push_back(e);
    endfunction

    function void compare_field(string name, logic signed [31:0] e, logic signed [31:0] a);
      if (a !== e) begin
        $error("%s: expected %0d, actual %0d", name, e, a);
        errors++;
      end
    endfunction

    function void check_result(rmjd_result_t got);
      rmjd_result_t e;
      if (waiting.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      e = waiting.pop_front();
      compare_field("mean_temperature", $signed(e.mean_temperature),
                    $signed(got.mean_temperature));
      compare_field("mean_humidity", e.mean_humidity, got.mean_humidity);
      compare_field("sample_count", e.sample_count, got.sample_count);
      compare_field("rapid_change", e.rapid_change, got.rapid_change);
      compare_field("previous_temperature", $signed(e.previous_temperature),
                    $signed(got.previous_temperature));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  rmjd_sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  rmjd_result_t result;
  logic cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  bit rx_stalls = 1'b1;
  mean_scoreboard sb;

  running_mean_jump_detector u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: checks accepted result words, stalls on its own pattern while rx_stalls is set
  initial begin
    bit ready_now;
    int run_left;
    ready_now = 1'b1;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) sb.check_result(result);
      if (!rx_stalls) begin
        result_ready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          ready_now = !ready_now;
          if (ready_now) run_left = $urandom_range(1, 40);
          else if ($urandom_range(0, 4) == 0) run_left = $urandom_range(20, 50);
          else run_left = $urandom_range(1, 6);
        end
        run_left--;
        result_ready <= ready_now;
      end
    end
  end

  task automatic send_word(logic signed [TEMP_W-1:0] t, logic [HUM_W-1:0] h);
    rmjd_sample_t w;
    w.temperature = t;
    w.humidity = h;
    sample <= w;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    sb.note_sample(w);
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    do @(posedge clk); while (sb.waiting.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.jump_limit = v;
  endtask

  // mostly a walk around the previous temperature so the flag sits near the limit
  function automatic logic signed [TEMP_W-1:0] pick_temp(longint prev, longint lim);
    longint v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = -1;
        default: v = 0;
      endcase
    end else if (r < 25) begin
      v = $signed(TEMP_W'($urandom));
    end else begin
      v = prev + longint'($urandom_range(0, 2 * lim + 4)) - (lim + 2);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end
    return TEMP_W'(v);
  endfunction

  function automatic logic [HUM_W-1:0] pick_hum();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 0;
        1: return 1;
        2: return 10000;
        default: return 16383;
      endcase
    end
    if (r < 22) return HUM_W'($urandom);
    return HUM_W'($urandom_range(0, 10000));
  endfunction

  task automatic run_phase(int items, bit gaps, bit mid_pause);
    int burst;
    burst = $urandom_range(1, 24);
    for (int i = 0; i < items; i++) begin
      send_word(pick_temp(sb.last_temp, longint'(sb.jump_limit)), pick_hum());
      if (mid_pause && i == items / 2) begin
        wait_drained();
      end else if (gaps) begin
        burst--;
        if (burst == 0) begin
          sample_valid <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst = $urandom_range(1, 24);
        end
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limit [6];
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: flag boundaries, reset marker, genuine -1, humidity extremes
    rx_stalls = 1'b0;
    send_word(100, 0);
    send_word(151, 16383);
    send_word(201, 10000);
    send_word(-32768, 1);
    send_word(32767, 8191);
    send_word(-1, 0);
    send_word(500, 5000);
    send_word(0, 9999);
    send_word(0, 10000);
    wait_drained();
    write_limit(16'd0);
    send_word(0, 0);
    send_word(1, 1);
    send_word(1, 2);
    wait_drained();
    write_limit(16'hffff);
    send_word(32767, 16383);
    send_word(-32768, 0);
    send_word(0, 100);
    send_word(-32768, 200);
    wait_drained();

    phase_limit[0] = LIMIT_W'($urandom);
    phase_limit[1] = 16'd0;
    phase_limit[2] = 16'hffff;
    phase_limit[3] = 16'd1;
    phase_limit[4] = LIMIT_W'($urandom_range(0, 300));
    phase_limit[5] = JUMP_LIMIT_RESET;
    for (int p = 0; p < 6; p++) begin
      rx_stalls = (p != 3);
      write_limit(phase_limit[p]);
      run_phase(255, (p % 2) == 0, p == 2);
    end

    // short tail under a fresh random limit
    rx_stalls = 1'b0;
    write_limit(LIMIT_W'($urandom));
    run_phase(4, 1'b0, 1'b0);

    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.waiting.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/rmjd_pkg.sv
design/rmjd_mean_unit.sv
design/running_mean_jump_detector.sv
dv/tb_running_mean_jump_detector.sv
